@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define KME_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define KME_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/kme_pkg.sv @@
// ----------------------------------------------------------------------------
// kme_pkg
// Shared constants, types and the character classifier of the k-mer encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kme_pkg;

    localparam int MAX_K_DEF  = 31;
    localparam int KSIZE_W    = 5;
    localparam int CHAR_W     = 8;
    localparam int CODE_W     = 61;
    localparam int STATUS_W   = 2;
    localparam int TDATA_S_W  = 8;
    localparam int TDATA_M_W  = 64;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_BAD_SIZE = 2'd2
    } status_t;

    // character classes: 0..3 base code, then degenerate, then other
    localparam logic [2:0] CLS_DEGEN = 3'd4;
    localparam logic [2:0] CLS_OTHER = 3'd5;

    typedef struct packed {
        logic                valid;
        logic [CODE_W-1:0]   code;
        status_t             status;
    } res_t;

    function automatic logic [2:0] letter_class(input logic [4:0] idx);
        logic [2:0] cls;
        case (idx)
            5'd0:    cls = 3'd0;        // A
            5'd2:    cls = 3'd1;        // C
            5'd6:    cls = 3'd2;        // G
            5'd19:   cls = 3'd3;        // T
            5'd1, 5'd3, 5'd7, 5'd10, 5'd12, 5'd13, 5'd17, 5'd18, 5'd21, 5'd22, 5'd24:
                     cls = CLS_DEGEN;   // B D H K M N R S V W Y
            default: cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

    function automatic logic [2:0] classify(input logic [CHAR_W-1:0] c);
        logic [2:0] cls;
        if (c >= 8'h41 && c <= 8'h5A) begin
            cls = letter_class(5'(c - 8'h41));
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            cls = letter_class(5'(c - 8'h61));
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

endpackage

@@ design/kme_cfg.sv @@
// ----------------------------------------------------------------------------
// kme_cfg
// APB register file: k-mer size and degenerate-skip mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kme_cfg #(
    parameter int MAX_K = kme_pkg::MAX_K_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [kme_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [kme_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [kme_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [kme_pkg::KSIZE_W-1:0]      kmer_size,
    output logic                             skip_degenerate
);

    localparam logic REG_KMER_SIZE = 1'b0;
    localparam logic REG_SKIP      = 1'b1;

    logic [kme_pkg::KSIZE_W-1:0] kmer_size_reg;
    logic                        skip_reg;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_size_reg <= kme_pkg::KSIZE_W'(MAX_K);
            skip_reg      <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_KMER_SIZE: kmer_size_reg <= pwdata[kme_pkg::KSIZE_W-1:0];
                REG_SKIP:      skip_reg      <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_KMER_SIZE: prdata = kme_pkg::APB_DATA_W'(kmer_size_reg);
            REG_SKIP:      prdata = kme_pkg::APB_DATA_W'(skip_reg);
        endcase
    end

    assign kmer_size       = kmer_size_reg;
    assign skip_degenerate = skip_reg;

endmodule

@@ design/kme_pack.sv @@
// ----------------------------------------------------------------------------
// kme_pack
// Canonical code builder: picks strand by middle base, squeezes middle to 1 bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kme_pack #(
    parameter int MAX_K = kme_pkg::MAX_K_DEF
) (
    input  logic [2*MAX_K-1:0]              fwd,
    input  logic [2*MAX_K-1:0]              rev,
    input  logic [kme_pkg::KSIZE_W-1:0]     k,
    output logic [kme_pkg::CODE_W-1:0]      code
);

    localparam int WIN_W = 2 * MAX_K;
    localparam int CW    = 2 * MAX_K - 1;
    localparam int IDX_W = (WIN_W > 1) ? $clog2(WIN_W) : 1;
    localparam int SH_W  = kme_pkg::KSIZE_W + 1;

    logic [WIN_W-1:0] fw;
    logic [WIN_W-1:0] rv;
    logic [WIN_W-1:0] src;
    logic [SH_W-1:0]  rv_sh;
    logic [CW-1:0]    lo_mask;
    logic [CW-1:0]    packed_code;

    always_comb begin
        fw      = fwd & ~({WIN_W{1'b1}} << {k, 1'b0});
        rv_sh   = SH_W'(WIN_W) - {k, 1'b0};
        rv      = rev >> rv_sh;
        // high bit of the middle base set: G or T, take the reverse strand
        src     = fw[IDX_W'(k)] ? rv : fw;
        lo_mask = ~({CW{1'b1}} << k);
        packed_code = (src[CW-1:0] & lo_mask) | (src[WIN_W-1:1] & ~lo_mask);
        code    = kme_pkg::CODE_W'(packed_code);
    end

endmodule

@@ design/kme_window.sv @@
// ----------------------------------------------------------------------------
// kme_window
// Sequence state: shift windows, run counters, halt flag and result decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module kme_window #(
    parameter int MAX_K = kme_pkg::MAX_K_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             fire,
    input  logic [kme_pkg::CHAR_W-1:0]       base_char,
    input  logic                             seq_last,
    input  logic [kme_pkg::KSIZE_W-1:0]      kmer_size,
    input  logic                             skip_degenerate,
    output logic                             bad_size,
    output kme_pkg::res_t                    res
);

    localparam int WIN_W = 2 * MAX_K;
    localparam int CNT_W = $clog2(MAX_K + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_K);

    logic [WIN_W-1:0] fwd_reg, fwd_next, fwd_upd;
    logic [WIN_W-1:0] rev_reg, rev_next, rev_upd;
    logic [CNT_W-1:0] fill_reg, fill_next, fill_upd;
    logic [CNT_W-1:0] clean_reg, clean_next, clean_upd;
    logic [CNT_W-1:0] since_reg, since_next, since_upd;
    logic             halted_reg, halted_next;

    logic [2:0]                    cls;
    logic [1:0]                    base_v;
    logic                          full, has_degen, has_bad;
    logic [kme_pkg::CODE_W-1:0]    code;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    assign bad_size = (kmer_size == '0) || !kmer_size[0]
                   || (kmer_size > kme_pkg::KSIZE_W'(MAX_K));

    always_comb begin
        cls       = kme_pkg::classify(base_char);
        base_v    = cls[2] ? 2'b00 : cls[1:0];
        fwd_upd   = WIN_W'({fwd_reg, base_v});
        rev_upd   = WIN_W'({~base_v, rev_reg} >> 2);
        fill_upd  = sat_inc(fill_reg);
        clean_upd = (cls == kme_pkg::CLS_DEGEN) ? '0 : sat_inc(clean_reg);
        since_upd = (cls == kme_pkg::CLS_OTHER) ? '0 : sat_inc(since_reg);
        full      = kme_pkg::KSIZE_W'(fill_upd) >= kmer_size;
        has_degen = kme_pkg::KSIZE_W'(clean_upd) < kmer_size;
        has_bad   = kme_pkg::KSIZE_W'(since_upd) < kmer_size;
    end

    kme_pack #(.MAX_K(MAX_K)) u_pack (
        .fwd  (fwd_upd),
        .rev  (rev_upd),
        .k    (kmer_size),
        .code (code)
    );

    always_comb begin
        fwd_next    = fwd_reg;
        rev_next    = rev_reg;
        fill_next   = fill_reg;
        clean_next  = clean_reg;
        since_next  = since_reg;
        halted_next = halted_reg;
        res         = '0;
        res.status  = kme_pkg::ST_OK;
        if (fire) begin
            if (!bad_size && !halted_reg) begin
                fwd_next   = fwd_upd;
                rev_next   = rev_upd;
                fill_next  = fill_upd;
                clean_next = clean_upd;
                since_next = since_upd;
                if (full && !(skip_degenerate && has_degen)) begin
                    res.valid = 1'b1;
                    if (has_degen || has_bad) begin
                        res.status  = kme_pkg::ST_INVALID;
                        halted_next = 1'b1;
                    end else begin
                        res.code = code;
                    end
                end
            end
            if (bad_size) begin
                res.valid  = 1'b1;
                res.status = kme_pkg::ST_BAD_SIZE;
            end
            if (bad_size || seq_last) begin
                fwd_next    = '0;
                rev_next    = '0;
                fill_next   = '0;
                clean_next  = '0;
                since_next  = CNT_MAX;
                halted_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg    <= '0;
            rev_reg    <= '0;
            fill_reg   <= '0;
            clean_reg  <= '0;
            since_reg  <= CNT_MAX;
            halted_reg <= 1'b0;
        end else begin
            fwd_reg    <= fwd_next;
            rev_reg    <= rev_next;
            fill_reg   <= fill_next;
            clean_reg  <= clean_next;
            since_reg  <= since_next;
            halted_reg <= halted_next;
        end
    end

    `KME_ASSERT_IMP(a_halt_after_error, $rose(halted_reg),
        $past(res.valid && res.status == kme_pkg::ST_INVALID), "halt without error result")
    `KME_ASSERT_NXT(a_last_clears, fire && seq_last,
        fill_reg == '0 && !halted_reg && since_reg == CNT_MAX, "sequence end did not clear")

endmodule

@@ design/canonical_kmer_encoder.sv @@
// ----------------------------------------------------------------------------
// canonical_kmer_encoder
// Streams ASCII bases in, emits canonical 2k-1 bit k-mer codes and status.
// ----------------------------------------------------------------------------
//  Channel  | Ports        | Contents
//  ---------+--------------+------------------------------------------------
//  input    | s_t*         | tdata: base_char; tlast: seq_last
//  result   | m_t*         | tdata: kmer_code; tuser: status
//  config   | APB p*       | 0x0 kmer_size, 0x4 skip_degenerate
//
//  One character per cycle sustained unless m_tready stalls; each character
//  passes the input register, then sequence state plus result register.
//  Stalls on m_tready propagate back through the input register to s_tready.
//  Synchronous active-low reset; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module canonical_kmer_encoder #(
    parameter int MAX_K = kme_pkg::MAX_K_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [kme_pkg::TDATA_S_W-1:0]    s_tdata,   // [7:0] base_char
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [kme_pkg::TDATA_M_W-1:0]    m_tdata,   // [60:0] kmer_code, zero pad
    output logic [kme_pkg::STATUS_W-1:0]     m_tuser,   // [1:0] status
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [kme_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [kme_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [kme_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [kme_pkg::KSIZE_W-1:0] kmer_size;
    logic                        skip_degenerate;

    logic                         in_valid_reg, in_valid_next;
    logic [kme_pkg::CHAR_W-1:0]   in_char_reg;
    logic                         in_last_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [kme_pkg::CODE_W-1:0]   out_code_reg;
    kme_pkg::status_t             out_status_reg;

    logic           advance, s_xfer, fire, bad_size;
    kme_pkg::res_t  res;

    kme_cfg #(.MAX_K(MAX_K)) u_cfg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .kmer_size       (kmer_size),
        .skip_degenerate (skip_degenerate)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;
    assign fire     = in_valid_reg && advance;

    kme_window #(.MAX_K(MAX_K)) u_window (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .fire            (fire),
        .base_char       (in_char_reg),
        .seq_last        (in_last_reg),
        .kmer_size       (kmer_size),
        .skip_degenerate (skip_degenerate),
        .bad_size        (bad_size),
        .res             (res)
    );

    always_comb begin
        in_valid_next  = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? (fire && res.valid) : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_char_reg <= s_tdata[kme_pkg::CHAR_W-1:0];
            in_last_reg <= s_tlast;
        end
        if (fire && res.valid) begin
            out_code_reg   <= res.code;
            out_status_reg <= res.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = kme_pkg::TDATA_M_W'(out_code_reg);
    assign m_tuser  = out_status_reg;

    `KME_ASSERT_NXT(a_bad_size_result, fire && bad_size,
        m_tvalid && m_tuser == kme_pkg::ST_BAD_SIZE, "bad size item gave no status result")
    `KME_ASSERT_IMP(a_error_code_zero, m_tvalid && m_tuser != kme_pkg::ST_OK,
        m_tdata == '0, "error result carries a nonzero code")
    `KME_ASSERT_IMP(a_code_width, m_tvalid && m_tuser == kme_pkg::ST_OK,
        (m_tdata >> ({kmer_size, 1'b0} - 1'b1)) == '0, "code wider than 2k-1 bits")

endmodule
